>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the buddy block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int WORD_W     = 32;
  localparam int WPOS_W     = 5;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int BC_W       = 13;
  localparam int SIZE_W     = 40;
  localparam int ADDR_W     = 64;

  localparam logic [BC_W-1:0] BC_RESET = 13'd4096;

  // register index bit of paddr
  localparam logic CFG_IDX_BASE  = 1'b0;
  localparam logic CFG_IDX_COUNT = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_POOL_FULL = 3'd2,
    STAT_NO_FREE   = 3'd3,
    STAT_NULL_ADDR = 3'd4,
    STAT_NOT_ALLOC = 3'd5
  } bba_status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } bba_func_t;

  typedef struct packed {
    bba_func_t           func;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   address;
  } bba_cmd_t;

  typedef struct packed {
    bba_status_t         status;
    logic [ADDR_W-1:0]   block_address;
    logic [BC_W-1:0]     block_pages;
  } bba_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pool_base;
    logic [BC_W-1:0]     page_total;
    logic                init_req;
  } bba_cfg_t;

  // bit edit request for the word unit; b is the buddy bit pos^1
  typedef struct packed {
    logic [WPOS_W-1:0]   pos;
    logic                wr_a;
    logic                val_a;
    logic                wr_b;
    logic                val_b;
  } bba_wop_t;

  typedef struct packed {
    logic                cur_a;
    logic                cur_b;
    logic                found;
    logic [WPOS_W-1:0]   ff_pos;
  } bba_wstat_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_A_SIZE,
    ST_A_CHK,
    ST_A_LVL,
    ST_A_SRD,
    ST_A_SCHK,
    ST_A_RD,
    ST_A_WR,
    ST_A_REC,
    ST_F_NULL,
    ST_F_RNG,
    ST_F_TRD,
    ST_F_TBL,
    ST_F_RD,
    ST_F_WR,
    ST_F_END,
    ST_DONE
  } bba_state_t;

endpackage

`default_nettype wire

>>> src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// generic single-port-write, registered-read ram
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/bba_word_unit.sv
// ----------------------------------------------------------------------------
// bba_word_unit
// shared bitmap word unit: first-set search, bit/buddy probe and edit
// ----------------------------------------------------------------------------
`default_nettype none

module bba_word_unit (
  input  wire logic [bba_pkg::WORD_W-1:0] word,
  input  wire bba_pkg::bba_wop_t          op,
  output bba_pkg::bba_wstat_t             stat,
  output logic [bba_pkg::WORD_W-1:0]      word_new
);

  logic [bba_pkg::WPOS_W-1:0] pos_b;

  assign pos_b = op.pos ^ bba_pkg::WPOS_W'(1);

  always_comb begin
    stat.cur_a  = word[op.pos];
    stat.cur_b  = word[pos_b];
    stat.found  = |word;
    stat.ff_pos = '0;
    // lowest set bit wins
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        stat.ff_pos = bba_pkg::WPOS_W'(i);
      end
    end
  end

  always_comb begin
    word_new = word;
    if (op.wr_a) begin
      word_new[op.pos] = op.val_a;
    end
    if (op.wr_b) begin
      word_new[pos_b] = op.val_b;
    end
  end

endmodule

`default_nettype wire

>>> src/bba_cfg.sv
// ----------------------------------------------------------------------------
// bba_cfg
// apb register file: pool base and page count
// ----------------------------------------------------------------------------
`default_nettype none

module bba_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [bba_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [bba_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output bba_pkg::bba_cfg_t                     cfg
);

  logic wr;
  logic sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign sel    = paddr[bba_pkg::CFG_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_base  <= '0;
      cfg.page_total <= bba_pkg::BC_RESET;
      cfg.init_req   <= 1'b0;
    end else begin
      cfg.init_req <= wr && (sel == bba_pkg::CFG_IDX_COUNT);
      if (wr && sel == bba_pkg::CFG_IDX_BASE) begin
        cfg.pool_base <= pwdata;
      end
      if (wr && sel == bba_pkg::CFG_IDX_COUNT) begin
        cfg.page_total <= pwdata[bba_pkg::BC_W-1:0];
      end
    end
  end

  assign prdata = (sel == bba_pkg::CFG_IDX_COUNT) ?
                  bba_pkg::CFG_DATA_W'(cfg.page_total) : cfg.pool_base;

endmodule

`default_nettype wire

>>> src/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// binary buddy page allocator with per-level free bitmaps in ram
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; busy then stays
// high through the single result beat, which shows on result with
// result_valid for exactly one cycle and must be taken then, since the
// receiver cannot stall. busy is also high in the cycle right after a page
// count write. One command runs through a small sequencer around one bitmap
// word unit and one bitmap ram port, so its length varies: an allocate sizes
// the request, checks and takes the top block, looks at each level in turn,
// scans bitmap words at the chosen level, splits down level by level and
// then records and reports; a free checks for a null address and the range,
// reads the size record and merges level by level. Refused commands end
// early. The length is set mostly by the word scan (up to 128 words at the
// lowest level) and the read-modify-write of the bitmap ram. After reset and
// after every page count write a clearing pass writes the initial contents
// of the bitmap and size record rams; no command is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module buddy_block_allocator #(
  parameter int MAX_PAGES  = 4096,
  parameter int LEVELS     = 13,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command side
  input  wire logic                             start,
  output logic                                  busy,
  input  wire bba_pkg::bba_cmd_t                cmd,
  // result side
  output logic                                  result_valid,
  output bba_pkg::bba_res_t                     result,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [bba_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [bba_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready
);

  // page count, page index, level index and level count widths
  localparam int PW     = $clog2(MAX_PAGES + 1);
  localparam int IW     = $clog2(MAX_PAGES);
  localparam int LIW    = $clog2(LEVELS);
  localparam int LCW    = $clog2(LEVELS + 1);
  // bitmap words per level and bitmap ram geometry: {level, word}
  localparam int WPL    = (MAX_PAGES + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int WAW    = (WPL > 1) ? $clog2(WPL) : 1;
  localparam int BAW    = LIW + WAW;
  localparam int BDEPTH = 2 ** BAW;
  // clearing pass covers both rams
  localparam int CLR_N  = (BDEPTH > MAX_PAGES) ? BDEPTH : MAX_PAGES;
  localparam int CNW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  // size record: {valid, level}
  localparam int TW     = LIW + 1;

  bba_pkg::bba_cfg_t   cfg;
  bba_pkg::bba_state_t state, state_next;

  logic [PW-1:0]  pages_eff;
  logic [LCW-1:0] levels_eff;
  logic [PW-1:0]  used_pages;
  logic [PW-1:0]  pages;
  logic [PW-1:0]  lfc [LEVELS];
  logic [LCW-1:0] lv;
  logic [LCW-1:0] bl;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  page;
  logic [WAW-1:0] wcnt;
  logic           top;
  logic [64:0]    diff;
  logic [CNW-1:0] clr_cnt;
  bba_pkg::bba_cmd_t cmd_q;
  bba_pkg::bba_res_t res;

  // config-derived sizes
  logic [31:0]    bc32;
  logic [PW-1:0]  pages_new;
  logic [LCW-1:0] levels_new;

  // bitmap ram and size record ram ports
  logic                       bm_we;
  logic [BAW-1:0]             bm_addr;
  logic [bba_pkg::WORD_W-1:0] bm_wdata;
  logic [bba_pkg::WORD_W-1:0] bm_rdata;
  logic [bba_pkg::WORD_W-1:0] bm_edit;
  logic                       tb_we;
  logic [IW-1:0]              tb_addr;
  logic [TW-1:0]              tb_wdata;
  logic [TW-1:0]              tb_rdata;

  bba_pkg::bba_wop_t   wop;
  bba_pkg::bba_wstat_t wst;

  // sequencer conditions
  logic [PW-1:0]  lvl_cnt;
  logic [PW-1:0]  pages_bl;
  logic [PW:0]    used_sum;
  logic           size_gt;
  logic           clr_last;
  logic           lfc_zero;
  logic           scan_last;
  logic           buddy_ok;
  logic [IW-1:0]  page_a;
  logic [63:0]    pg;
  logic           pg_out;
  logic [LCW-1:0] tb_lvl;
  logic           tb_valid;
  logic [LIW-1:0] lvi;
  logic           res_bad;

  // clearing pass word contents
  logic [LIW-1:0]             clr_lv;
  logic [WAW-1:0]             clr_w;
  logic [PW-1:0]              clr_lc;
  logic [PW-1:0]              clr_tail;
  logic                       clr_set;
  logic [bba_pkg::WORD_W-1:0] clr_word;

  bba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bba_ram #(.W(bba_pkg::WORD_W), .D(BDEPTH)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_addr),
    .wdata (bm_wdata),
    .raddr (bm_addr),
    .rdata (bm_rdata)
  );

  bba_ram #(.W(TW), .D(MAX_PAGES)) u_record (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_addr),
    .wdata (tb_wdata),
    .raddr (tb_addr),
    .rdata (tb_rdata)
  );

  bba_word_unit u_word (
    .word     (bm_rdata),
    .op       (wop),
    .stat     (wst),
    .word_new (bm_edit)
  );

  // effective pool size and level count for a new page count
  assign bc32      = 32'(cfg.page_total);
  assign pages_new = (bc32 > 32'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(bc32);

  always_comb begin
    levels_new = '0;
    for (int j = 0; j < PW; j++) begin
      if (pages_new[j]) begin
        levels_new = (j + 1 > LEVELS) ? LCW'(LEVELS) : LCW'(j + 1);
      end
    end
  end

  assign lvi       = lv[LIW-1:0];
  assign lvl_cnt   = pages_eff >> lv;
  assign pages_bl  = PW'(1) << bl;
  assign used_sum  = {1'b0, used_pages} + {1'b0, pages_bl};
  assign size_gt   = {1'b0, cmd_q.request_size} > (41'd1 << (PAGE_SHIFT + int'(bl)));
  assign clr_last  = (clr_cnt == CNW'(CLR_N - 1));
  assign lfc_zero  = (lfc[lvi] == '0);
  assign scan_last = (wcnt == WAW'(WPL - 1));
  assign buddy_ok  = wst.cur_b && (PW'(idx ^ IW'(1)) < lvl_cnt);
  assign page_a    = IW'(idx << bl);
  assign pg        = diff[63:0] >> PAGE_SHIFT;
  assign pg_out    = diff[64] || (pg >= 64'(pages_eff));
  assign tb_valid  = tb_rdata[TW-1];
  assign tb_lvl    = LCW'(tb_rdata[LIW-1:0]);

  // tail block of an odd-count level starts out free
  assign clr_lv   = clr_cnt[BAW-1:WAW];
  assign clr_w    = clr_cnt[WAW-1:0];
  assign clr_lc   = pages_eff >> clr_lv;
  assign clr_tail = clr_lc - PW'(1);
  assign clr_set  = (LCW'(clr_lv) < levels_eff) && clr_lc[0] &&
                    (WAW'(clr_tail >> bba_pkg::WPOS_W) == clr_w);
  assign clr_word = clr_set ? (bba_pkg::WORD_W'(1) << bba_pkg::WPOS_W'(clr_tail)) : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_INIT:   state_next = bba_pkg::ST_CLEAR;
      bba_pkg::ST_CLEAR:  if (clr_last) state_next = bba_pkg::ST_IDLE;
      bba_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (cmd.func == bba_pkg::FUNC_ALLOC) ? bba_pkg::ST_A_SIZE :
                                                            bba_pkg::ST_F_NULL;
        end
      end
      bba_pkg::ST_A_SIZE: begin
        if (!(bl < levels_eff && size_gt)) state_next = bba_pkg::ST_A_CHK;
      end
      bba_pkg::ST_A_CHK: begin
        if (bl >= levels_eff || used_sum > {1'b0, pages_eff}) begin
          state_next = bba_pkg::ST_DONE;
        end else begin
          state_next = bba_pkg::ST_A_LVL;
        end
      end
      bba_pkg::ST_A_LVL: begin
        if (lv >= levels_eff) state_next = bba_pkg::ST_DONE;
        else if (!lfc_zero) state_next = bba_pkg::ST_A_SRD;
      end
      bba_pkg::ST_A_SRD:  state_next = bba_pkg::ST_A_SCHK;
      bba_pkg::ST_A_SCHK: begin
        if (wst.found) state_next = bba_pkg::ST_A_RD;
        else if (scan_last) state_next = bba_pkg::ST_A_LVL;
        else state_next = bba_pkg::ST_A_SRD;
      end
      bba_pkg::ST_A_RD:   state_next = bba_pkg::ST_A_WR;
      bba_pkg::ST_A_WR:   state_next = (lv > bl) ? bba_pkg::ST_A_RD : bba_pkg::ST_A_REC;
      bba_pkg::ST_A_REC:  state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_F_NULL: begin
        state_next = (cmd_q.address == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_F_RNG;
      end
      bba_pkg::ST_F_RNG:  state_next = pg_out ? bba_pkg::ST_DONE : bba_pkg::ST_F_TRD;
      bba_pkg::ST_F_TRD:  state_next = bba_pkg::ST_F_TBL;
      bba_pkg::ST_F_TBL: begin
        if (!tb_valid || tb_lvl >= levels_eff) state_next = bba_pkg::ST_DONE;
        else state_next = bba_pkg::ST_F_RD;
      end
      bba_pkg::ST_F_RD:   state_next = bba_pkg::ST_F_WR;
      bba_pkg::ST_F_WR: begin
        if (buddy_ok && (lv + LCW'(1) < levels_eff)) state_next = bba_pkg::ST_F_RD;
        else state_next = bba_pkg::ST_F_END;
      end
      bba_pkg::ST_F_END:  state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_DONE:   state_next = bba_pkg::ST_IDLE;
      default:            state_next = bba_pkg::ST_INIT;
    endcase
    // a page count write rebuilds the pool
    if (cfg.init_req) state_next = bba_pkg::ST_INIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // ram controls and word unit request
  always_comb begin
    // no command is taken while a page count write is pending
    busy         = (state != bba_pkg::ST_IDLE) || cfg.init_req;
    result_valid = (state == bba_pkg::ST_DONE);
    result       = res;
    bm_we        = 1'b0;
    bm_addr      = {lvi, WAW'(idx >> bba_pkg::WPOS_W)};
    bm_wdata     = bm_edit;
    tb_we        = 1'b0;
    tb_addr      = page;
    tb_wdata     = '0;
    wop          = '0;
    wop.pos      = bba_pkg::WPOS_W'(idx);
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        bm_addr  = clr_cnt[BAW-1:0];
        bm_we    = ({1'b0, clr_cnt} < (CNW + 1)'(BDEPTH));
        bm_wdata = clr_word;
        tb_addr  = clr_cnt[IW-1:0];
        tb_we    = ({1'b0, clr_cnt} < (CNW + 1)'(MAX_PAGES));
      end
      bba_pkg::ST_A_SRD, bba_pkg::ST_A_SCHK: begin
        bm_addr = {lvi, wcnt};
      end
      bba_pkg::ST_A_WR: begin
        wop.wr_a  = 1'b1;
        wop.val_a = 1'b0;
        wop.wr_b  = !top;
        wop.val_b = 1'b1;
        bm_we     = 1'b1;
      end
      bba_pkg::ST_A_REC: begin
        tb_addr  = page_a;
        tb_we    = 1'b1;
        tb_wdata = {1'b1, bl[LIW-1:0]};
      end
      bba_pkg::ST_F_TBL: begin
        tb_we = tb_valid;
      end
      bba_pkg::ST_F_WR: begin
        wop.wr_a  = 1'b1;
        wop.val_a = !buddy_ok;
        wop.wr_b  = buddy_ok;
        wop.val_b = 1'b0;
        bm_we     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_eff  <= '0;
      levels_eff <= '0;
      used_pages <= '0;
      clr_cnt    <= '0;
    end else begin
      unique case (state)
        bba_pkg::ST_INIT: begin
          pages_eff  <= pages_new;
          levels_eff <= levels_new;
          used_pages <= '0;
          clr_cnt    <= '0;
          for (int j = 0; j < LEVELS; j++) begin
            lfc[j] <= PW'(LCW'(j) < levels_new && pages_new[j]);
          end
        end
        bba_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + CNW'(1);
        end
        bba_pkg::ST_IDLE: begin
          cmd_q <= cmd;
          bl    <= '0;
          res   <= '0;
        end
        bba_pkg::ST_A_SIZE: begin
          if (bl < levels_eff && size_gt) bl <= bl + LCW'(1);
        end
        bba_pkg::ST_A_CHK: begin
          lv  <= bl;
          top <= 1'b1;
          if (bl >= levels_eff) res.status <= bba_pkg::STAT_TOO_LARGE;
          else if (used_sum > {1'b0, pages_eff}) res.status <= bba_pkg::STAT_POOL_FULL;
        end
        bba_pkg::ST_A_LVL: begin
          wcnt <= '0;
          if (lv >= levels_eff) res.status <= bba_pkg::STAT_NO_FREE;
          else if (lfc_zero) lv <= lv + LCW'(1);
        end
        bba_pkg::ST_A_SCHK: begin
          if (wst.found) begin
            idx <= IW'({wcnt, wst.ff_pos});
          end else if (scan_last) begin
            lv <= lv + LCW'(1);
          end else begin
            wcnt <= wcnt + WAW'(1);
          end
        end
        bba_pkg::ST_A_WR: begin
          // clear the taken block, free its right half below the top
          lfc[lvi] <= lfc[lvi] + PW'(!top && !wst.cur_b) - PW'(wst.cur_a);
          if (lv > bl) begin
            lv  <= lv - LCW'(1);
            idx <= idx << 1;
            top <= 1'b0;
          end
        end
        bba_pkg::ST_A_REC: begin
          used_pages          <= used_sum[PW-1:0];
          res.status          <= bba_pkg::STAT_OK;
          res.block_address   <= cfg.pool_base + (64'(page_a) << PAGE_SHIFT);
          res.block_pages     <= bba_pkg::BC_W'(pages_bl);
        end
        bba_pkg::ST_F_NULL: begin
          diff <= {1'b0, cmd_q.address} - {1'b0, cfg.pool_base};
          if (cmd_q.address == '0) res.status <= bba_pkg::STAT_NULL_ADDR;
        end
        bba_pkg::ST_F_RNG: begin
          page <= IW'(pg);
          if (pg_out) res.status <= bba_pkg::STAT_NOT_ALLOC;
        end
        bba_pkg::ST_F_TBL: begin
          lv    <= tb_lvl;
          pages <= PW'(1) << tb_lvl;
          idx   <= page >> tb_lvl;
          if (!tb_valid || tb_lvl >= levels_eff) res.status <= bba_pkg::STAT_NOT_ALLOC;
        end
        bba_pkg::ST_F_WR: begin
          // merge with a free buddy, else leave this block free
          if (buddy_ok) begin
            lfc[lvi] <= lfc[lvi] - PW'(wst.cur_a) - PW'(1);
            idx      <= idx >> 1;
            lv       <= lv + LCW'(1);
          end else begin
            lfc[lvi] <= lfc[lvi] + PW'(!wst.cur_a);
          end
        end
        bba_pkg::ST_F_END: begin
          used_pages      <= (used_pages >= pages) ? used_pages - pages : '0;
          res.status      <= bba_pkg::STAT_OK;
          res.block_pages <= bba_pkg::BC_W'(pages);
        end
        default: begin
        end
      endcase
    end
  end

  // refused beat
  assign res_bad = result_valid && (result.status != bba_pkg::STAT_OK);

  // checks
  `BBA_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `BBA_ASSERT_NXT(a_strobe_once, result_valid, !result_valid)
  `BBA_ASSERT_IMP(a_fail_zero, res_bad, result.block_pages == '0 && result.block_address == '0)
  `BBA_ASSERT_IMP(a_used_bound, 1'b1, used_pages <= pages_eff)

endmodule

`default_nettype wire
